FILE: hdl/swe_pkg.sv
// Shared types, constants and helpers of the stack word executor.
`default_nettype none

package swe_pkg;

    // Default sizes of the stores.
    localparam int STACK_DEPTH_DEF   = 32;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MEM_BYTES_DEF     = 4096;

    // Field widths fixed by the interface.
    localparam int WORD_W      = 48;
    localparam int SYL_W       = 12;
    localparam int SYL_VAL_W   = 10;
    localparam int NUM_SYL     = 4;
    localparam int IDX_W       = 4;
    localparam int BASE_W      = 12;
    localparam int LIMIT_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 32;
    localparam int DEPTH_OUT_W = 6;
    localparam int STATUS_W    = 3;
    localparam int TSIZE_W     = 5;
    localparam int TSIZE_RESET = 16;

    // Entries that the four-bit entry index can reach.
    localparam int IDX_REACH = 16;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Stream widths.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 2;

    // Item kinds.
    typedef enum logic [1:0] {
        ACT_DESC_WR = 2'd0,
        ACT_MEM_WR  = 2'd1,
        ACT_EXEC    = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_BADDESC   = 3'd3,
        ST_READFAULT = 3'd4,
        ST_UNDERFLOW = 3'd5
    } t_status;

    // Syllable types.
    localparam logic [1:0] SYL_LOAD  = 2'd0;
    localparam logic [1:0] SYL_DESC  = 2'd1;
    localparam logic [1:0] SYL_LIT   = 2'd2;
    localparam logic [1:0] SYL_ARITH = 2'd3;

    // Arithmetic syllable values.
    localparam logic [SYL_VAL_W-1:0] OP_ADD = 10'd0;
    localparam logic [SYL_VAL_W-1:0] OP_SUB = 10'd1;

    // Classified item as it travels from front to back.
    typedef struct packed {
        t_action             action;
        logic [WORD_W-1:0]   word;
        logic [IDX_W-1:0]    entry_index;
        logic [ADDR_W-1:0]   seg_base;
        logic                limit_nz;
        logic                present;
        logic [ADDR_W-1:0]   mem_addr;
        logic [BYTE_W-1:0]   mem_byte;
    } t_cmd;

    // Reduces a 12-bit address modulo the memory size. For a modulus of at least
    // 256 the quotient is below 16, so four compare-subtract steps suffice.
    function automatic logic [ADDR_W-1:0] wrap_addr(
        input logic [BASE_W-1:0] addr,
        input logic [16:0]       modulus
    );
        logic [19:0] rem;
        logic [19:0] step;
        rem = {8'd0, addr};
        for (int k = 3; k >= 0; k--) begin
            step = {3'd0, modulus} << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/swe_front.sv
// Front part: accepts stream transfers, classifies them and wraps addresses.
`default_nettype none

module swe_front #(
    parameter int MEM_BYTES = swe_pkg::MEM_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [swe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [swe_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output swe_pkg::t_cmd                      o_cmd
);

    logic          r_valid;
    swe_pkg::t_cmd r_cmd;
    swe_pkg::t_cmd n_cmd;

    // Field extraction and address wrapping.
    always_comb begin
        n_cmd.action      = swe_pkg::t_action'(s_axis_tuser);
        n_cmd.word        = s_axis_tdata[47:0];
        n_cmd.entry_index = s_axis_tdata[51:48];
        n_cmd.seg_base    = swe_pkg::wrap_addr(s_axis_tdata[63:52], 17'(MEM_BYTES));
        n_cmd.limit_nz    = (s_axis_tdata[79:64] != 16'd0);
        n_cmd.present     = s_axis_tdata[80];
        n_cmd.mem_addr    = swe_pkg::wrap_addr(s_axis_tdata[92:81], 17'(MEM_BYTES));
        n_cmd.mem_byte    = s_axis_tdata[100:93];
    end

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign o_cmd_valid   = r_valid;
    assign o_cmd         = r_cmd;

    // Holding register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swe_queue.sv
// Short queue of classified items between the front and back parts.
`default_nettype none

module swe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire swe_pkg::t_cmd i_in_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output swe_pkg::t_cmd      o_out_cmd
);

    localparam int PTR_W = (swe_pkg::QUEUE_DEPTH > 1) ? $clog2(swe_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(swe_pkg::QUEUE_DEPTH + 1);

    swe_pkg::t_cmd    r_slot [swe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_in_ready  = (r_count != CNT_W'(swe_pkg::QUEUE_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_cmd   = r_slot[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(swe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(swe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_in_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swe_back.sv
// Back part: descriptor table, byte memory, evaluation stack and syllable sequencer.
`default_nettype none

module swe_back #(
    parameter int STACK_DEPTH   = swe_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = swe_pkg::TABLE_ENTRIES_DEF,
    parameter int MEM_BYTES     = swe_pkg::MEM_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wen,
    input  wire logic [swe_pkg::TSIZE_W-1:0]    i_cfg_wdata,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_ready,
    input  wire swe_pkg::t_cmd                  i_cmd,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [swe_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int TBL_STORE = (TABLE_ENTRIES < swe_pkg::IDX_REACH) ?
                               TABLE_ENTRIES : swe_pkg::IDX_REACH;
    localparam int TIDX_W    = (TBL_STORE > 1) ? $clog2(TBL_STORE) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W    = $clog2(STACK_DEPTH);
    localparam int MADDR_W   = $clog2(MEM_BYTES);
    localparam int DW        = swe_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYL,
        S_LOAD,
        S_ALU,
        S_DONE
    } t_state;

    // Control and datapath registers.
    t_state                          r_state;
    logic [CNT_W-1:0]                r_cnt;
    logic [DW-1:0]                   r_tos;
    swe_pkg::t_status                r_status;
    logic [swe_pkg::WORD_W-1:0]      r_word;
    logic [1:0]                      r_syl;
    logic                            r_sub;
    logic [swe_pkg::TSIZE_W-1:0]     r_tsize;
    logic                            r_ovalid;
    swe_pkg::t_status                r_o_status;
    logic [swe_pkg::DEPTH_OUT_W-1:0] r_o_depth;
    logic [DW-1:0]                   r_o_top;

    t_state                          n_state;
    logic [CNT_W-1:0]                n_cnt;
    logic [DW-1:0]                   n_tos;
    swe_pkg::t_status                n_status;
    logic [swe_pkg::WORD_W-1:0]      n_word;
    logic [1:0]                      n_syl;
    logic                            n_sub;

    // Stores.
    logic                            r_present [TBL_STORE];
    logic                            r_lnz     [TBL_STORE];
    logic [MADDR_W-1:0]              r_base    [TBL_STORE];
    logic [swe_pkg::BYTE_W-1:0]      r_mem     [MEM_BYTES];
    logic [DW-1:0]                   r_body    [STACK_DEPTH];
    logic [swe_pkg::BYTE_W-1:0]      r_rd;
    logic [DW-1:0]                   r_nos;

    // Decode helpers.
    logic [swe_pkg::SYL_W-1:0]       syl;
    logic [1:0]                      syl_kind;
    logic [swe_pkg::SYL_VAL_W-1:0]   syl_val;
    logic [TIDX_W-1:0]               tidx;
    logic                            desc_ok;
    logic [CNT_W-1:0]                cnt_m1;
    logic [CNT_W-1:0]                cnt_m2;
    logic [TIDX_W-1:0]               widx;

    // Control outputs of the sequencer.
    logic                            tbl_we;
    logic                            mem_we;
    logic                            body_we;
    logic                            out_load;
    logic                            push_req;
    logic [DW-1:0]                   push_data;
    logic                            advance;
    logic                            fail;
    swe_pkg::t_status                fail_code;

    assign syl      = r_word[swe_pkg::WORD_W-1 -: swe_pkg::SYL_W];
    assign syl_kind = syl[11:10];
    assign syl_val  = syl[9:0];
    assign tidx     = syl_val[TIDX_W-1:0];
    assign widx     = i_cmd.entry_index[TIDX_W-1:0];
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);

    // An entry is usable when it is inside the configured size, storable and present.
    assign desc_ok = (syl_val < {5'd0, r_tsize}) &&
                     (syl_val < swe_pkg::SYL_VAL_W'(TBL_STORE)) &&
                     r_present[tidx];

    // Sequencer next-state logic.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_tos     = r_tos;
        n_status  = r_status;
        n_word    = r_word;
        n_syl     = r_syl;
        n_sub     = r_sub;
        o_cmd_ready = 1'b0;
        tbl_we    = 1'b0;
        mem_we    = 1'b0;
        body_we   = 1'b0;
        out_load  = 1'b0;
        push_req  = 1'b0;
        push_data = '0;
        advance   = 1'b0;
        fail      = 1'b0;
        fail_code = swe_pkg::ST_OK;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_status = swe_pkg::ST_OK;
                    n_state  = S_DONE;
                    unique case (i_cmd.action)
                        swe_pkg::ACT_DESC_WR: begin
                            tbl_we = ({1'b0, i_cmd.entry_index} < 5'(TBL_STORE));
                        end
                        swe_pkg::ACT_MEM_WR: begin
                            mem_we = 1'b1;
                        end
                        swe_pkg::ACT_CLEAR: begin
                            n_cnt = '0;
                        end
                        swe_pkg::ACT_EXEC: begin
                            if (r_tsize == '0) begin
                                n_status = swe_pkg::ST_EMPTY;
                            end else begin
                                n_word  = i_cmd.word;
                                n_syl   = '0;
                                n_state = S_SYL;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SYL: begin
                case (syl_kind)
                    swe_pkg::SYL_LIT: begin
                        push_req  = 1'b1;
                        push_data = DW'(syl_val);
                    end
                    swe_pkg::SYL_DESC: begin
                        if (!desc_ok) begin
                            fail      = 1'b1;
                            fail_code = swe_pkg::ST_BADDESC;
                        end else begin
                            push_req  = 1'b1;
                            push_data = DW'(r_base[tidx]);
                        end
                    end
                    swe_pkg::SYL_LOAD: begin
                        if (!desc_ok) begin
                            fail      = 1'b1;
                            fail_code = swe_pkg::ST_BADDESC;
                        end else if (!r_lnz[tidx]) begin
                            fail      = 1'b1;
                            fail_code = swe_pkg::ST_READFAULT;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                    default: begin
                        if (syl_val == swe_pkg::OP_ADD || syl_val == swe_pkg::OP_SUB) begin
                            if (r_cnt < CNT_W'(2)) begin
                                fail      = 1'b1;
                                fail_code = swe_pkg::ST_UNDERFLOW;
                            end else begin
                                n_sub   = (syl_val == swe_pkg::OP_SUB);
                                n_state = S_ALU;
                            end
                        end else begin
                            advance = 1'b1;
                        end
                    end
                endcase
            end
            S_LOAD: begin
                push_req  = 1'b1;
                push_data = DW'(r_rd);
            end
            S_ALU: begin
                n_tos   = r_sub ? (r_nos - r_tos) : (r_nos + r_tos);
                n_cnt   = cnt_m1;
                advance = 1'b1;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Push onto the stack; the old top moves into the body.
        if (push_req) begin
            if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                fail      = 1'b1;
                fail_code = swe_pkg::ST_OVERFLOW;
            end else begin
                body_we = (r_cnt != '0);
                n_tos   = push_data;
                n_cnt   = r_cnt + CNT_W'(1);
                advance = 1'b1;
            end
        end

        // The first error ends the word.
        if (fail) begin
            n_status = fail_code;
            n_state  = S_DONE;
        end

        // Step to the next syllable or finish the word.
        if (advance) begin
            if (r_syl == 2'(swe_pkg::NUM_SYL - 1)) begin
                n_status = swe_pkg::ST_OK;
                n_state  = S_DONE;
            end else begin
                n_syl   = r_syl + 2'd1;
                n_word  = r_word << swe_pkg::SYL_W;
                n_state = S_SYL;
            end
        end
    end

    // Sequencer state, stack control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tsize  <= swe_pkg::TSIZE_W'(swe_pkg::TSIZE_RESET);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wen) begin
                r_tsize <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_tos    <= n_tos;
        r_status <= n_status;
        r_word   <= n_word;
        r_syl    <= n_syl;
        r_sub    <= n_sub;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_depth  <= swe_pkg::DEPTH_OUT_W'(r_cnt);
            r_o_top    <= (r_cnt == '0) ? '0 : r_tos;
        end
    end

    // Descriptor table; present bits clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < TBL_STORE; e++) begin
                r_present[e] <= 1'b0;
            end
        end else if (tbl_we) begin
            r_present[widx] <= i_cmd.present;
        end
        if (tbl_we) begin
            r_lnz[widx]  <= i_cmd.limit_nz;
            r_base[widx] <= i_cmd.seg_base[MADDR_W-1:0];
        end
    end

    // Byte memory with registered read at the addressed descriptor's base.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.mem_addr[MADDR_W-1:0]] <= i_cmd.mem_byte;
        end
        r_rd <= r_mem[r_base[tidx]];
    end

    // Stack body below the top register, with registered read of the second entry.
    always_ff @(posedge i_clk) begin
        if (body_we) begin
            r_body[cnt_m1[SIDX_W-1:0]] <= r_tos;
        end
        r_nos <= r_body[cnt_m2[SIDX_W-1:0]];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_o_top, r_o_depth, r_o_status};

endmodule

`default_nettype wire

FILE: hdl/stack_word_executor.sv
// An execute item runs through the back part's sequencer one syllable at a time, with
// an extra state for each memory load or add/subtract; write and clear items go straight
// to the result state. The sequencer takes a new item only once the last one's result is
// loaded into the output register, and it holds while that register is full and not taken.
// Reset (synchronous, active low) empties the stack and queue, marks every descriptor
// not present and sets the table size to 16; the byte memory keeps its contents.
`default_nettype none

module stack_word_executor #(
    parameter int STACK_DEPTH   = swe_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = swe_pkg::TABLE_ENTRIES_DEF,
    parameter int MEM_BYTES     = swe_pkg::MEM_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Table size register write.
    input  wire logic                          i_cfg_wen,
    input  wire logic [swe_pkg::TSIZE_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // word, entry_index, entry_base, entry_limit, entry_present, mem_address, mem_byte
    input  wire logic [swe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  wire logic [swe_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status, stack_depth, top_value
    output logic [swe_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    logic          front_valid;
    logic          front_ready;
    swe_pkg::t_cmd front_cmd;
    logic          queue_valid;
    logic          queue_ready;
    swe_pkg::t_cmd queue_cmd;

    swe_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (front_valid),
        .i_cmd_ready   (front_ready),
        .o_cmd         (front_cmd)
    );

    swe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (front_valid),
        .o_in_ready  (front_ready),
        .i_in_cmd    (front_cmd),
        .o_out_valid (queue_valid),
        .i_out_ready (queue_ready),
        .o_out_cmd   (queue_cmd)
    );

    swe_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MEM_BYTES     (MEM_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd_valid   (queue_valid),
        .o_cmd_ready   (queue_ready),
        .i_cmd         (queue_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: dv/stack_word_executor_tb.sv
// Self-checking testbench for the stack word executor: directed and random streams.
`timescale 1ns / 100ps

module stack_word_executor_tb;

    // One input transfer as packed on s_axis_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  mem_val;
        logic [11:0] mem_addr;
        logic        present;
        logic [15:0] limit;
        logic [11:0] base;
        logic [3:0]  idx;
        logic [47:0] word;
    } t_item_fields;

    // One result transfer as packed on m_axis_tdata.
    typedef struct packed {
        logic [6:0]       pad;
        logic [31:0]      top;
        logic [5:0]       depth;
        swe_pkg::t_status status;
    } t_exec_result;

    // Tracks the executor's state and the results it must produce, in order.
    class t_word_exec_scoreboard;
        logic [31:0]  stack_mem [swe_pkg::STACK_DEPTH_DEF];
        int unsigned  depth;
        logic [11:0]  desc_base [swe_pkg::TABLE_ENTRIES_DEF];
        logic [15:0]  desc_limit [swe_pkg::TABLE_ENTRIES_DEF];
        bit           desc_present [swe_pkg::TABLE_ENTRIES_DEF];
        logic [7:0]   mem_bytes [swe_pkg::MEM_BYTES_DEF];
        int unsigned  table_size;
        t_exec_result expected_results [$];
        int           errors;
        int           checked;
        int           status_hits [6];

        function new();
            depth = 0;
            table_size = swe_pkg::TSIZE_RESET;
            errors = 0;
            checked = 0;
            foreach (desc_present[i]) begin
                desc_present[i] = 1'b0;
                desc_base[i] = '0;
                desc_limit[i] = '0;
            end
            foreach (mem_bytes[i]) mem_bytes[i] = '0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void set_table_size(logic [4:0] value);
            table_size = value;
        endfunction

        // Runs the four syllables of a word against the stack; the first error stops it.
        function swe_pkg::t_status execute_word(logic [47:0] w);
            int unsigned lim;
            logic [11:0] syl;
            logic [1:0]  kind;
            logic [9:0]  val;
            logic [31:0] pushed;
            logic [31:0] a;
            logic [31:0] b;
            lim = (table_size > swe_pkg::TABLE_ENTRIES_DEF) ?
                  swe_pkg::TABLE_ENTRIES_DEF : table_size;
            if (lim == 0) return swe_pkg::ST_EMPTY;
            for (int i = 0; i < swe_pkg::NUM_SYL; i++) begin
                syl = w[47 - 12 * i -: 12];
                kind = syl[11:10];
                val = syl[9:0];
                if (kind == swe_pkg::SYL_ARITH) begin
                    if (val == swe_pkg::OP_ADD || val == swe_pkg::OP_SUB) begin
                        if (depth < 2) return swe_pkg::ST_UNDERFLOW;
                        b = stack_mem[depth - 1];
                        a = stack_mem[depth - 2];
                        depth--;
                        stack_mem[depth - 1] = (val == swe_pkg::OP_ADD) ? a + b : a - b;
                    end
                end else begin
                    if (kind == swe_pkg::SYL_LIT) begin
                        pushed = {22'd0, val};
                    end else begin
                        if (val >= lim || !desc_present[val[3:0]]) return swe_pkg::ST_BADDESC;
                        if (kind == swe_pkg::SYL_LOAD) begin
                            if (desc_limit[val[3:0]] == 0) return swe_pkg::ST_READFAULT;
                            pushed = {24'd0, mem_bytes[desc_base[val[3:0]]]};
                        end else begin
                            pushed = {20'd0, desc_base[val[3:0]]};
                        end
                    end
                    if (depth >= swe_pkg::STACK_DEPTH_DEF) return swe_pkg::ST_OVERFLOW;
                    stack_mem[depth] = pushed;
                    depth++;
                end
            end
            return swe_pkg::ST_OK;
        endfunction

        // Applies an accepted input transfer and queues the result it must cause.
        function void note_transfer(swe_pkg::t_action act, t_item_fields f);
            t_exec_result res;
            res = '0;
            res.status = swe_pkg::ST_OK;
            case (act)
                swe_pkg::ACT_DESC_WR: begin
                    desc_base[f.idx] = f.base;
                    desc_limit[f.idx] = f.limit;
                    desc_present[f.idx] = f.present;
                end
                swe_pkg::ACT_MEM_WR: begin
                    mem_bytes[f.mem_addr] = f.mem_val;
                end
                swe_pkg::ACT_EXEC: begin
                    res.status = execute_word(f.word);
                end
                default: begin
                    depth = 0;
                end
            endcase
            res.depth = depth[5:0];
            res.top = (depth > 0) ? stack_mem[depth - 1] : 32'd0;
            status_hits[res.status]++;
            expected_results.push_back(res);
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_result(t_exec_result act_res);
            t_exec_result exp_res;
            if (expected_results.size() == 0) begin
                $error("result with no expectation: status %0d depth %0d top %0d",
                       act_res.status, act_res.depth, $signed(act_res.top));
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            checked++;
            if (act_res.status !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, act_res.status);
                errors++;
            end
            if (act_res.depth !== exp_res.depth) begin
                $error("stack_depth: expected %0d, actual %0d", exp_res.depth, act_res.depth);
                errors++;
            end
            if (act_res.top !== exp_res.top) begin
                $error("top_value: expected %0d, actual %0d",
                       $signed(exp_res.top), $signed(act_res.top));
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wen;
    logic [swe_pkg::TSIZE_W-1:0]   i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // word, entry_index, entry_base, entry_limit, entry_present, mem_address, mem_byte
    logic [swe_pkg::S_TDATA_W-1:0] s_axis_tdata;
    // action
    logic [swe_pkg::S_TUSER_W-1:0] s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // status, stack_depth, top_value
    logic [swe_pkg::M_TDATA_W-1:0] m_axis_tdata;

    t_word_exec_scoreboard scoreboard = new();

    // Stimulus-side view: which bytes hold data and which bases the entries point to.
    bit          mem_written [swe_pkg::MEM_BYTES_DEF];
    logic [11:0] gen_base [swe_pkg::TABLE_ENTRIES_DEF];
    int          items_sent = 0;
    int          cfg_writes = 0;
    bit          send_quiet = 1'b0;

    stack_word_executor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // Input and result monitors sample at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            scoreboard.note_transfer(swe_pkg::t_action'(s_axis_tuser),
                                     t_item_fields'(s_axis_tdata));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            scoreboard.check_result(t_exec_result'(m_axis_tdata));
        end
    end

    // Result side backpressure: a random stall before each transfer, with quiet stretches.
    initial begin
        int stall;
        bit quiet;
        quiet = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 49) == 0) quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic t_item_fields random_fields();
        logic [127:0] raw;
        t_item_fields f;
        raw = {$urandom, $urandom, $urandom, $urandom};
        f = raw[103:0];
        f.pad = '0;
        return f;
    endfunction

    // Mostly well-formed syllables, with descriptor numbers near the table size.
    function automatic logic [11:0] random_syllable();
        int r;
        logic [9:0] val;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 8) val = 10'($urandom_range(0, 17));
        else if ($urandom_range(0, 1) == 0) val = 10'($urandom_range(0, 31));
        else val = 10'($urandom_range(0, 1023));
        if (r < 35) return {swe_pkg::SYL_LIT, 10'($urandom_range(0, 1023))};
        if (r < 55) return {swe_pkg::SYL_DESC, val};
        if (r < 75) return {swe_pkg::SYL_LOAD, val};
        if (r < 96) begin
            return {swe_pkg::SYL_ARITH,
                    ($urandom_range(0, 1) == 0) ? swe_pkg::OP_ADD : swe_pkg::OP_SUB};
        end
        return {swe_pkg::SYL_ARITH, 10'($urandom_range(0, 1023))};
    endfunction

    // Presents one item after a random gap and holds it until the transfer.
    task automatic put_transfer(input swe_pkg::t_action act, input t_item_fields f);
        int gap;
        if ($urandom_range(0, 59) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Sends an item; a descriptor never points at a byte that was never written.
    task automatic send_item(input swe_pkg::t_action act, input t_item_fields f);
        t_item_fields fill;
        if (act == swe_pkg::ACT_DESC_WR && !mem_written[f.base]) begin
            fill = random_fields();
            fill.mem_addr = f.base;
            mem_written[f.base] = 1'b1;
            put_transfer(swe_pkg::ACT_MEM_WR, fill);
        end
        if (act == swe_pkg::ACT_MEM_WR) mem_written[f.mem_addr] = 1'b1;
        if (act == swe_pkg::ACT_DESC_WR) gen_base[f.idx] = f.base;
        put_transfer(act, f);
    endtask

    task automatic send_mem(input logic [11:0] addr, input logic [7:0] val);
        t_item_fields f;
        f = random_fields();
        f.mem_addr = addr;
        f.mem_val = val;
        send_item(swe_pkg::ACT_MEM_WR, f);
    endtask

    task automatic send_desc(input logic [3:0] idx, input logic [11:0] base,
                             input logic [15:0] limit, input logic present);
        t_item_fields f;
        f = random_fields();
        f.idx = idx;
        f.base = base;
        f.limit = limit;
        f.present = present;
        send_item(swe_pkg::ACT_DESC_WR, f);
    endtask

    task automatic send_exec(input logic [11:0] s0, input logic [11:0] s1,
                             input logic [11:0] s2, input logic [11:0] s3);
        t_item_fields f;
        f = random_fields();
        f.word = {s0, s1, s2, s3};
        send_item(swe_pkg::ACT_EXEC, f);
    endtask

    task automatic send_clear();
        send_item(swe_pkg::ACT_CLEAR, random_fields());
    endtask

    // Drops valid right after the last transfer, then waits for every result.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (scoreboard.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only while the block is idle.
    task automatic write_table_size(input logic [4:0] value);
        drain();
        repeat (16) @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        scoreboard.set_table_size(value);
        cfg_writes++;
    endtask

    // One random item: mostly executes, with table and memory updates and clears mixed in.
    task automatic send_random_item();
        int r;
        t_item_fields f;
        r = $urandom_range(0, 99);
        f = random_fields();
        if (r < 55) begin
            if ($urandom_range(0, 6) != 0) begin
                f.word = {random_syllable(), random_syllable(),
                          random_syllable(), random_syllable()};
            end
            send_item(swe_pkg::ACT_EXEC, f);
        end else if (r < 70) begin
            if ($urandom_range(0, 3) == 0) f.limit = '0;
            f.present = ($urandom_range(0, 4) != 0);
            send_item(swe_pkg::ACT_DESC_WR, f);
        end else if (r < 85) begin
            if ($urandom_range(0, 1) == 0) f.mem_addr = gen_base[$urandom_range(0, 15)];
            send_item(swe_pkg::ACT_MEM_WR, f);
        end else if (r < 90) begin
            send_item(swe_pkg::ACT_CLEAR, f);
        end else begin
            send_item(swe_pkg::t_action'($urandom_range(0, 3)), f);
        end
    endtask

    // Main sequence.
    initial begin
        logic [4:0] phase_sizes [10];
        phase_sizes = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd5, 5'd17, 5'd2, 5'd16, 5'd31, 5'd9};
        foreach (mem_written[i]) mem_written[i] = 1'b0;
        foreach (gen_base[i]) gen_base[i] = '0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = swe_pkg::ACT_DESC_WR;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset table size: field extremes and every error but the empty table.
        send_mem(12'd0, 8'hFF);
        send_mem(12'hFFF, 8'h5A);
        send_mem(12'h123, 8'h80);
        send_desc(4'd0, 12'd0, 16'hFFFF, 1'b1);
        send_desc(4'd15, 12'hFFF, 16'd1, 1'b1);
        send_desc(4'd3, 12'h123, 16'd0, 1'b1);
        send_desc(4'd7, 12'h123, 16'd9, 1'b0);
        send_exec({swe_pkg::SYL_LIT, 10'h3FF}, {swe_pkg::SYL_LIT, 10'd0},
                  {swe_pkg::SYL_LOAD, 10'd0}, {swe_pkg::SYL_DESC, 10'd15});
        send_exec({swe_pkg::SYL_ARITH, swe_pkg::OP_ADD}, {swe_pkg::SYL_ARITH, swe_pkg::OP_SUB},
                  {swe_pkg::SYL_ARITH, 10'd2}, {swe_pkg::SYL_ARITH, 10'h3FF});
        send_exec({swe_pkg::SYL_LOAD, 10'd15}, {swe_pkg::SYL_LOAD, 10'd3},
                  {swe_pkg::SYL_LIT, 10'd1}, {swe_pkg::SYL_LIT, 10'd1});
        send_exec({swe_pkg::SYL_DESC, 10'd7}, {swe_pkg::SYL_LIT, 10'd2},
                  {swe_pkg::SYL_LIT, 10'd2}, {swe_pkg::SYL_LIT, 10'd2});
        send_exec({swe_pkg::SYL_DESC, 10'd16}, {swe_pkg::SYL_LIT, 10'd2},
                  {swe_pkg::SYL_LIT, 10'd2}, {swe_pkg::SYL_LIT, 10'd2});
        send_exec({swe_pkg::SYL_LOAD, 10'h3FF}, {swe_pkg::SYL_LIT, 10'd2},
                  {swe_pkg::SYL_LIT, 10'd2}, {swe_pkg::SYL_LIT, 10'd2});
        send_clear();
        send_exec({swe_pkg::SYL_ARITH, swe_pkg::OP_ADD}, {swe_pkg::SYL_LIT, 10'd1},
                  {swe_pkg::SYL_LIT, 10'd1}, {swe_pkg::SYL_LIT, 10'd1});
        send_clear();
        send_exec({swe_pkg::SYL_LIT, 10'd5}, {swe_pkg::SYL_ARITH, swe_pkg::OP_SUB},
                  {swe_pkg::SYL_LIT, 10'd1}, {swe_pkg::SYL_LIT, 10'd1});
        send_exec({swe_pkg::SYL_LIT, 10'd1}, {swe_pkg::SYL_LIT, 10'd2},
                  {swe_pkg::SYL_ARITH, swe_pkg::OP_SUB}, {swe_pkg::SYL_ARITH, 10'd7});
        send_clear();
        // Fill the stack to its limit, then add and push until it overflows.
        repeat (8) begin
            send_exec({swe_pkg::SYL_LIT, 10'h2AA}, {swe_pkg::SYL_LIT, 10'h155},
                      {swe_pkg::SYL_DESC, 10'd0}, {swe_pkg::SYL_LOAD, 10'd15});
        end
        send_exec({swe_pkg::SYL_ARITH, swe_pkg::OP_ADD}, {swe_pkg::SYL_LIT, 10'd3},
                  {swe_pkg::SYL_LIT, 10'd4}, {swe_pkg::SYL_LIT, 10'd5});
        send_clear();

        // Random phases, each under its own table size.
        foreach (phase_sizes[p]) begin
            write_table_size(phase_sizes[p]);
            repeat (125) send_random_item();
        end

        drain();
        repeat (30) @(posedge i_clk);
        $display("Sent %0d items over %0d table size settings, %0d results checked.",
                 items_sent, cfg_writes, scoreboard.checked);
        $display("Status mix: ok %0d, empty %0d, overflow %0d, bad descriptor %0d, %s %0d, %s %0d",
                 scoreboard.status_hits[swe_pkg::ST_OK],
                 scoreboard.status_hits[swe_pkg::ST_EMPTY],
                 scoreboard.status_hits[swe_pkg::ST_OVERFLOW],
                 scoreboard.status_hits[swe_pkg::ST_BADDESC],
                 "read fault", scoreboard.status_hits[swe_pkg::ST_READFAULT],
                 "underflow", scoreboard.status_hits[swe_pkg::ST_UNDERFLOW]);
        if (scoreboard.errors == 0 && scoreboard.expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/swe_pkg.sv
hdl/swe_front.sv
hdl/swe_queue.sv
hdl/swe_back.sv
hdl/stack_word_executor.sv
dv/stack_word_executor_tb.sv
